/* hw/rtl/tlf_pkg.sv */
// Shared types, constants and helpers for the text line folder.
package tlf_pkg;

  localparam int MAX_WIDTH = 63;
  localparam int PTR_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_FOLD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_SPC  = 2'd1;

  localparam logic OPC_TEXT = 1'b0;

  typedef enum logic [1:0] {
    CMD_TEXT,
    CMD_NEWLINE,
    CMD_EOI
  } tlf_kind_t;

  typedef struct packed {
    tlf_kind_t         kind;
    logic [BYTE_W-1:0] data;
  } tlf_cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0] width;   // already clamped to 1..MAX_WIDTH
    logic             spaces;
  } tlf_cfg_t;

  function automatic tlf_cmd_t classify(input logic opcode, input logic [BYTE_W-1:0] data);
    tlf_cmd_t c;
    c.data = data;
    if (opcode != OPC_TEXT) begin
      c.kind = CMD_EOI;
    end else if (data == NEWLINE_CHAR) begin
      c.kind = CMD_NEWLINE;
    end else begin
      c.kind = CMD_TEXT;
    end
    return c;
  endfunction

  // add two indexes of the circular line store
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(MAX_WIDTH)) begin
      s = s - (PTR_W+1)'(MAX_WIDTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

/* hw/rtl/tlf_front.sv */
// Front end: classifies input words and queues them for the back end.
module tlf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tlf_pkg::BYTE_W-1:0] in_tdata,
  input  logic                       in_tuser,
  output logic                       q_valid,
  input  logic                       q_ready,
  output tlf_pkg::tlf_cmd_t          q_cmd
);

  tlf_pkg::tlf_cmd_t                entry_r [tlf_pkg::QDEPTH];
  logic [tlf_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tlf_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tlf_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             push, pop;

  assign in_tready = (count_r != tlf_pkg::QCNT_W'(tlf_pkg::QDEPTH));
  assign q_valid   = (count_r != '0);
  assign q_cmd     = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= tlf_pkg::classify(in_tuser, in_tdata);
    end
  end

endmodule

/* hw/rtl/tlf_back.sv */
// Back end: line store, break search and byte output sequencer.
module tlf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlf_pkg::tlf_cfg_t          cfg,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  tlf_pkg::tlf_cmd_t          q_cmd,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tlf_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EMIT = 4'b0100,
    S_NL   = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tlf_pkg::PTR_W-1:0]    head_r, head_nxt;
  logic [tlf_pkg::PTR_W-1:0]    fill_r, fill_nxt;
  logic [tlf_pkg::PTR_W-1:0]    idx_r, idx_nxt;
  logic [tlf_pkg::PTR_W-1:0]    chunk_r, chunk_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         append_r, append_nxt;
  logic [tlf_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tlf_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [tlf_pkg::BYTE_W-1:0]   mem [tlf_pkg::MAX_WIDTH];
  logic [tlf_pkg::BYTE_W-1:0]   rd_data_r;
  logic [tlf_pkg::PTR_W-1:0]    rd_addr, wr_addr;
  logic [tlf_pkg::BYTE_W-1:0]   wr_data;
  logic                         we;
  logic                         out_ok;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_ok     = !out_valid_r || out_tready;
  assign rd_addr    = tlf_pkg::wrap_add(head_r, idx_r);
  // the append slot sits right after the stored bytes, before and after a chunk
  assign wr_addr    = tlf_pkg::wrap_add(head_r, fill_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    chunk_nxt     = chunk_r;
    rd_ok_nxt     = rd_ok_r;
    append_nxt    = append_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    we            = 1'b0;
    wr_data       = byte_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready    = 1'b1;
          append_nxt = 1'b0;
          idx_nxt    = '0;
          rd_ok_nxt  = 1'b0;
          chunk_nxt  = fill_r;
          case (q_cmd.kind)
            tlf_pkg::CMD_EOI: begin
              if (fill_r != '0) begin
                state_nxt = S_EMIT;
              end
            end
            tlf_pkg::CMD_NEWLINE: begin
              state_nxt = (fill_r != '0) ? S_EMIT : S_NL;
            end
            tlf_pkg::CMD_TEXT: begin
              byte_nxt = q_cmd.data;
              if (fill_r >= cfg.width) begin
                append_nxt = 1'b1;
                chunk_nxt  = cfg.width;
                if (cfg.spaces && cfg.width > tlf_pkg::PTR_W'(1)) begin
                  idx_nxt   = cfg.width - 1'b1;
                  state_nxt = S_SCAN;
                end else begin
                  state_nxt = S_EMIT;
                end
              end else begin
                we       = 1'b1;
                wr_data  = q_cmd.data;
                fill_nxt = fill_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // walk the window downward; index 0 never counts as a break
        if (rd_ok_r) begin
          rd_ok_nxt = 1'b0;
          if (rd_data_r == tlf_pkg::SPACE_CHAR) begin
            chunk_nxt = idx_r + 1'b1;
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end else if (idx_r == tlf_pkg::PTR_W'(1)) begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (!rd_ok_r) begin
          rd_ok_nxt = 1'b1;
        end else if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = 1'b0;
          rd_ok_nxt     = 1'b0;
          if ({1'b0, idx_r} + 1'b1 == {1'b0, chunk_r}) begin
            state_nxt = S_NL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_NL: begin
        if (out_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = tlf_pkg::NEWLINE_CHAR;
          out_last_nxt  = 1'b1;
          head_nxt      = tlf_pkg::wrap_add(head_r, chunk_r);
          fill_nxt      = fill_r - chunk_r;
          if (append_r) begin
            we       = 1'b1;
            fill_nxt = fill_r - chunk_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      rd_ok_r     <= 1'b0;
      append_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      rd_ok_r     <= rd_ok_nxt;
      append_r    <= append_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chunk_r    <= chunk_nxt;
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* hw/rtl/text_line_folder.sv */
// Top level of the text line folder: config registers, front end and back end.
//
// Usage: one word on the in_ channel carries one text byte (in_tdata) or, with
// in_tuser high, an end-of-input marker. Output words carry the folded text on
// out_tdata; out_tlast is high on the final byte caused by one input word,
// which is always a newline. A line that would grow past fold_width is broken
// by a newline, at the width or, with break_at_spaces set, after the last space
// of the window. Registers: index 0 fold_width (0 acts as 1), index 1
// break_at_spaces; cfg_ready is always high, write only while the block is idle.
// Timing: an accepted word waits in the queue, then the back end takes it; a
// plain byte that fits needs nothing more. A break or flush then reads the line
// store and loads the output word for each emitted byte, then the newline. A
// space search reads the store once per byte scanned. The line store's single
// read port sets this pace. A two-word queue between front and back keeps input
// flowing while the back end drains.
// Reset (synchronous, rst_n low) empties the store and queue and restores
// fold_width 63 and break_at_spaces 0. When out_tready is low the output
// word holds and the back end waits; the queue then fills and drops in_tready.
module text_line_folder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tlf_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] in_byte
  input  logic                          in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tlf_pkg::BYTE_W-1:0]    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlf_pkg::PTR_W-1:0]     cfg_data
);

  logic [tlf_pkg::PTR_W-1:0] fold_width_r;
  logic                      break_spc_r;
  tlf_pkg::tlf_cfg_t         cfg;
  tlf_pkg::tlf_cmd_t         q_cmd;
  logic                      q_valid, q_ready;

  assign cfg_ready  = 1'b1;
  assign cfg.width  = (fold_width_r == '0) ? tlf_pkg::PTR_W'(1) : fold_width_r;
  assign cfg.spaces = break_spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_width_r <= tlf_pkg::PTR_W'(tlf_pkg::MAX_WIDTH);
      break_spc_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tlf_pkg::REG_FOLD_WIDTH) begin
        fold_width_r <= cfg_data;
      end else if (cfg_index == tlf_pkg::REG_BREAK_SPC) begin
        break_spc_r <= cfg_data[0];
      end
    end
  end

  tlf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  tlf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/tlf_checker.sv */
// Port-level checks for the text line folder, bound to the top level.
module tlf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [tlf_pkg::BYTE_W-1:0]    in_tdata,
  input logic                          in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tlf_pkg::BYTE_W-1:0]    out_tdata,
  input logic                          out_tlast,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [tlf_pkg::PTR_W-1:0]     cfg_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // reset leaves no output word pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // stored text never holds a newline, so every newline out ends a run
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == tlf_pkg::NEWLINE_CHAR |-> out_tlast)
    else $error("newline without tlast");

  a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == tlf_pkg::NEWLINE_CHAR)
    else $error("run ends on a byte other than newline");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (.*);
